FILE: src/tbce_pkg.sv
// ============================================================================
// tbce_pkg
// Shared types, constants, chord table and helpers of the chord emulator.
// ============================================================================
`default_nettype none

package tbce_pkg;

    localparam int MASK_W    = 8;
    localparam int POS_W     = 16;
    localparam int EMU_W     = 3;
    localparam int TIMER_W   = 16;
    localparam int TDATA_W   = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int MAX_RES   = 3;
    localparam int CNT_W     = 2;

    localparam int NUM_STATES = 11;
    localparam int NUM_EVENTS = 4;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_POINTER = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_GROUND      = 4'd0,
        ST_DELAY_L     = 4'd1,
        ST_DELAY_R     = 4'd2,
        ST_MID         = 4'd3,
        ST_LEFT        = 4'd4,
        ST_RIGHT       = 4'd5,
        ST_MID_R_HELD  = 4'd6,
        ST_MID_L_HELD  = 4'd7,
        ST_MID_PLUS_L  = 4'd8,
        ST_MID_PLUS_R  = 4'd9,
        ST_LEFT_RIGHT  = 4'd10
    } fsm_state_t;

    typedef logic signed [2:0] action_t;

    localparam action_t A_NO = 3'sd0;
    localparam action_t A_PL = 3'sd1;
    localparam action_t A_PM = 3'sd2;
    localparam action_t A_PR = 3'sd3;
    localparam action_t A_RL = -3'sd1;
    localparam action_t A_RM = -3'sd2;
    localparam action_t A_RR = -3'sd3;

    typedef struct packed {
        action_t    act1;
        action_t    act2;
        fsm_state_t nxt;
    } fsm_entry_t;

    // rows: state; columns: no button, left, right, both
    localparam fsm_entry_t FSM_TABLE [NUM_STATES][NUM_EVENTS] = '{
        '{'{A_NO, A_NO, ST_GROUND}, '{A_NO, A_NO, ST_DELAY_L},
          '{A_NO, A_NO, ST_DELAY_R}, '{A_PM, A_NO, ST_MID}},
        '{'{A_PL, A_RL, ST_GROUND}, '{A_NO, A_NO, ST_DELAY_L},
          '{A_PL, A_RL, ST_DELAY_R}, '{A_PM, A_NO, ST_MID}},
        '{'{A_PR, A_RR, ST_GROUND}, '{A_PR, A_RR, ST_DELAY_L},
          '{A_NO, A_NO, ST_DELAY_R}, '{A_PM, A_NO, ST_MID}},
        '{'{A_RM, A_NO, ST_GROUND}, '{A_NO, A_NO, ST_MID_L_HELD},
          '{A_NO, A_NO, ST_MID_R_HELD}, '{A_NO, A_NO, ST_MID}},
        '{'{A_RL, A_NO, ST_GROUND}, '{A_NO, A_NO, ST_LEFT},
          '{A_RL, A_NO, ST_DELAY_R}, '{A_PR, A_NO, ST_LEFT_RIGHT}},
        '{'{A_RR, A_NO, ST_GROUND}, '{A_RR, A_NO, ST_DELAY_L},
          '{A_NO, A_NO, ST_RIGHT}, '{A_PL, A_NO, ST_LEFT_RIGHT}},
        '{'{A_RM, A_NO, ST_GROUND}, '{A_RM, A_NO, ST_DELAY_L},
          '{A_NO, A_NO, ST_MID_R_HELD}, '{A_PL, A_NO, ST_MID_PLUS_L}},
        '{'{A_RM, A_NO, ST_GROUND}, '{A_NO, A_NO, ST_MID_L_HELD},
          '{A_RM, A_NO, ST_DELAY_R}, '{A_PR, A_NO, ST_MID_PLUS_R}},
        '{'{A_RM, A_RL, ST_GROUND}, '{A_RM, A_NO, ST_LEFT},
          '{A_RL, A_NO, ST_MID_R_HELD}, '{A_NO, A_NO, ST_MID_PLUS_L}},
        '{'{A_RM, A_RR, ST_GROUND}, '{A_RR, A_NO, ST_MID_L_HELD},
          '{A_RM, A_NO, ST_RIGHT}, '{A_NO, A_NO, ST_MID_PLUS_R}},
        '{'{A_RL, A_RR, ST_GROUND}, '{A_RR, A_NO, ST_LEFT},
          '{A_RL, A_NO, ST_RIGHT}, '{A_NO, A_NO, ST_LEFT_RIGHT}}
    };

    typedef struct packed {
        op_t              op;
        logic [MASK_W-1:0] button_mask;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] out_mask;
        logic [POS_W-1:0]  out_x;
        logic [POS_W-1:0]  out_y;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] slot;
        logic [CNT_W-1:0]      count;
    } step_out_t;

    typedef struct packed {
        logic               emulate_enable;
        logic [TIMER_W-1:0] timeout_ticks;
    } cfg_t;

    function automatic logic has_timeout(input fsm_state_t s);
        return (s == ST_DELAY_L) || (s == ST_DELAY_R);
    endfunction

    function automatic logic [EMU_W-1:0] apply_action(input logic [EMU_W-1:0] em,
                                                      input action_t a);
        logic [EMU_W-1:0] r;
        logic [1:0]       mag;
        logic [1:0]       bit_idx;
        r       = em;
        mag     = a[2] ? (~a[1:0] + 2'd1) : a[1:0];
        bit_idx = mag - 2'd1;
        if (a != A_NO)
        begin
            r[bit_idx] = ~a[2];
        end
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] compose_mask(input logic [MASK_W-1:0] mask,
                                                      input logic [EMU_W-1:0] em);
        return {mask[7:3], em[2], mask[1] | em[1], em[0]};
    endfunction

endpackage

`default_nettype wire

FILE: src/tbce_core.sv
// ============================================================================
// tbce_core
// Chord state machine: state registers and single-pass step logic.
// ============================================================================
`default_nettype none

module tbce_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire tbce_pkg::item_t     item,
    input  wire tbce_pkg::cfg_t      cfg,
    output tbce_pkg::step_out_t      res
);
    import tbce_pkg::*;

    fsm_state_t          state_reg, state_next;
    logic [EMU_W-1:0]    emu_reg, emu_next;
    logic [MASK_W-1:0]   held_reg, held_next;
    logic [POS_W-1:0]    origin_x_reg, origin_x_next;
    logic [POS_W-1:0]    origin_y_reg, origin_y_next;
    logic [POS_W-1:0]    latest_x_reg, latest_x_next;
    logic [POS_W-1:0]    latest_y_reg, latest_y_next;
    logic                running_reg, running_next;
    logic [TIMER_W-1:0]  left_reg, left_next;

    fsm_entry_t          entry;
    logic [1:0]          ev;
    logic                delayed;
    logic [EMU_W-1:0]    em1, em2, em_t;
    action_t             t_act;
    fsm_state_t          t_state;
    logic                v0, v1, v2;
    result_t             c0, c1, c2;

    always_comb
    begin
        state_next    = state_reg;
        emu_next      = emu_reg;
        held_next     = held_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        latest_x_next = latest_x_reg;
        latest_y_next = latest_y_reg;
        running_next  = running_reg;
        left_next     = left_reg;

        ev      = {item.button_mask[2], item.button_mask[0]};
        entry   = FSM_TABLE[state_reg][ev];
        delayed = has_timeout(state_reg);
        em1     = apply_action(emu_reg, entry.act1);
        em2     = apply_action(em1, entry.act2);
        t_act   = (state_reg == ST_DELAY_L) ? A_PL : A_PR;
        t_state = (state_reg == ST_DELAY_L) ? ST_LEFT : ST_RIGHT;
        em_t    = apply_action(emu_reg, t_act);

        v0 = 1'b0;
        v1 = 1'b0;
        v2 = 1'b0;
        c0 = '{out_mask: compose_mask(item.button_mask, em1),
               out_x: item.pos_x, out_y: item.pos_y};
        c1 = '{out_mask: compose_mask(item.button_mask, em2),
               out_x: item.pos_x, out_y: item.pos_y};
        c2 = c1;

        if (item.op == OP_TICK)
        begin
            c0 = '{out_mask: compose_mask(held_reg, em_t),
                   out_x: origin_x_reg, out_y: origin_y_reg};
            c2 = '{out_mask: compose_mask(held_reg, em_t),
                   out_x: latest_x_reg, out_y: latest_y_reg};
            if (running_reg)
            begin
                if (left_reg > TIMER_W'(1))
                begin
                    left_next = left_reg - TIMER_W'(1);
                end
                else
                begin
                    running_next = 1'b0;
                    left_next    = '0;
                    if (delayed)
                    begin
                        v0         = 1'b1;
                        v2         = (origin_x_reg != latest_x_reg) ||
                                     (origin_y_reg != latest_y_reg);
                        emu_next   = em_t;
                        state_next = t_state;
                    end
                end
            end
        end
        else if (!cfg.emulate_enable)
        begin
            v0 = 1'b1;
            c0 = '{out_mask: item.button_mask, out_x: item.pos_x, out_y: item.pos_y};
        end
        else
        begin
            held_next     = item.button_mask;
            latest_x_next = item.pos_x;
            latest_y_next = item.pos_y;
            v0 = (entry.act1 != A_NO);
            v1 = (entry.act2 != A_NO);
            v2 = !v0 && !v1 && !running_reg;
            if (delayed && !entry.act1[2] && v0)
            begin
                c0.out_x = origin_x_reg;
                c0.out_y = origin_y_reg;
            end
            if (delayed && !entry.act2[2] && v1)
            begin
                c1.out_x = origin_x_reg;
                c1.out_y = origin_y_reg;
            end
            emu_next   = em2;
            state_next = entry.nxt;
            if (entry.nxt != state_reg)
            begin
                running_next = 1'b0;
                left_next    = '0;
                if (has_timeout(entry.nxt))
                begin
                    origin_x_next = item.pos_x;
                    origin_y_next = item.pos_y;
                    running_next  = 1'b1;
                    left_next     = (cfg.timeout_ticks != '0) ? cfg.timeout_ticks
                                                              : TIMER_W'(1);
                end
            end
        end

        // pack valid candidates to the front
        res.count   = CNT_W'({1'b0, v0}) + CNT_W'({1'b0, v1}) + CNT_W'({1'b0, v2});
        res.slot[2] = c2;
        if (v0)
        begin
            res.slot[0] = c0;
            res.slot[1] = v1 ? c1 : c2;
        end
        else if (v1)
        begin
            res.slot[0] = c1;
            res.slot[1] = c2;
        end
        else
        begin
            res.slot[0] = c2;
            res.slot[1] = c2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_GROUND;
            emu_reg      <= '0;
            held_reg     <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            latest_x_reg <= '0;
            latest_y_reg <= '0;
            running_reg  <= 1'b0;
            left_reg     <= '0;
        end
        else if (go)
        begin
            state_reg    <= state_next;
            emu_reg      <= emu_next;
            held_reg     <= held_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            latest_x_reg <= latest_x_next;
            latest_y_reg <= latest_y_next;
            running_reg  <= running_next;
            left_reg     <= left_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tbce_out_buf.sv
// ============================================================================
// tbce_out_buf
// Result register holding up to three items, drained one per cycle while m_tready is high.
// ============================================================================
`default_nettype none

module tbce_out_buf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire tbce_pkg::step_out_t            res,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tbce_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);
    import tbce_pkg::*;

    result_t [MAX_RES-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pop;

    assign pop      = (cnt_reg != '0) && m_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tdata  = {slot_reg[0].out_y, slot_reg[0].out_x, slot_reg[0].out_mask};

    always_comb
    begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (load)
        begin
            cnt_next  = res.count;
            slot_next = res.slot;
        end
        else if (pop)
        begin
            cnt_next     = cnt_reg - CNT_W'(1);
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

FILE: src/three_button_chord_emulator_unit.sv
// ============================================================================
// three_button_chord_emulator_unit
// Left+right chord to middle-button emulator for pointer event streams.
// ============================================================================
//  channel | direction | handshake          | content
//  s_*     | in        | s_tvalid/s_tready  | tuser op, tdata mask/x/y
//  m_*     | out       | m_tvalid/m_tready  | tdata mask/x/y, tlast end of item
//  cfg_*   | in        | cfg_we             | enable, timeout ticks
//
//  An item is held in the input register, then one pass through the state
//  machine loads 0..3 results into the result register. Results leave one
//  per cycle while m_tready is high; the next item loads into the result
//  register as the last result of the previous item leaves. The first result
//  is offered once the item has passed the input and result registers.
//  Reset clears flags and core state and sets the timeout to 50 ticks; data
//  registers keep their value; the hold timer is stopped, the state is ground.
// ============================================================================
`default_nettype none

module three_button_chord_emulator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tbce_pkg::TDATA_W-1:0]    s_tdata,   // button_mask, pos_x, pos_y
    input  wire logic                            s_tuser,   // operation
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tbce_pkg::TDATA_W-1:0]         m_tdata,   // out_mask, out_x, out_y
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [tbce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tbce_pkg::CFG_W-1:0]      cfg_data
);
    import tbce_pkg::*;

    item_t              item_reg, item_next;
    logic               in_valid_reg, in_valid_next;
    logic               enable_reg, enable_next;
    logic [TIMER_W-1:0] timeout_reg, timeout_next;
    logic               can_load;
    logic               load;
    cfg_t               cfg;
    step_out_t          res;

    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;
    assign cfg      = '{emulate_enable: enable_reg, timeout_ticks: timeout_reg};

    always_comb
    begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            item_next.op          = op_t'(s_tuser);
            item_next.button_mask = s_tdata[7:0];
            item_next.pos_x       = s_tdata[23:8];
            item_next.pos_y       = s_tdata[39:24];
            in_valid_next         = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        enable_next  = enable_reg;
        timeout_next = timeout_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:  enable_next  = cfg_data[0];
                CFG_TIMEOUT: timeout_next = cfg_data[TIMER_W-1:0];
                default:     enable_next  = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            enable_reg   <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            enable_reg   <= enable_next;
            timeout_reg  <= timeout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    tbce_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (load),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    tbce_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: src/tbce_checker.sv
// ============================================================================
// tbce_checker
// Port-level checks of the chord emulator, bound to the top level.
// ============================================================================
`default_nettype none

module tbce_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tbce_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic                          m_tlast
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while no result pending");

    // results of one item leave without gaps
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the results of one item");

    // input waits only while results are still pending
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result register");

endmodule

bind three_button_chord_emulator_unit tbce_checker u_tbce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
